[rtl/core/trb_pkg.sv]
// ----------------------------------------------------------------------------
// trb_pkg
// Shared constants, codes and controller/datapath interface types for the
// text row breaker.
// ----------------------------------------------------------------------------
package trb_pkg;

  localparam int MaxColumns  = 256;
  localparam int OffsetWidth = 24;
  localparam int MaxResults  = 3;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [15:0] ColMax = 16'hFFFF;

  localparam logic [1:0] KindLineBreak = 2'd0;
  localparam logic [1:0] KindWordWrap  = 2'd1;
  localparam logic [1:0] KindEndOfText = 2'd2;

  localparam logic [1:0] CfgTabWidth      = 2'd0;
  localparam logic [1:0] CfgWrapColumn    = 2'd1;
  localparam logic [1:0] CfgMinWrapColumn = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CR_LF,
    OP_CR_ROW,
    OP_ENQ,
    OP_MOD_START,
    OP_EVAL,
    OP_END_CR,
    OP_END_FINAL,
    OP_FLUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_cmd;
    logic crp;
    logic byte_is_lf;
    logic q_empty;
    logic ch_is_tab;
    logic mod_busy;
    logic ev_emits;
    logic emit_ok;
    logic staged_v;
    logic can_push;
  } dp_status_t;

  function automatic logic [15:0] sat_col(input logic [16:0] v);
    sat_col = v[16] ? ColMax : v[15:0];
  endfunction

endpackage

[rtl/core/text_row_breaker_with_word_wrap_unit.sv]
// ----------------------------------------------------------------------------
// text_row_breaker_with_word_wrap_unit
// Splits a byte stream into display rows with tab expansion and word wrap.
// ----------------------------------------------------------------------------
// Usage:
// The in channel carries one item per text byte (cmd_i low) or an end of
// text marker (cmd_i high). The out channel returns one item per finished
// row: its start offset, width, end kind and a flag on the last row caused
// by an input item. The cfg channel writes tab width, wrap column and minimum
// wrap column; it is always ready and should be used only while idle.
// One item is processed at a time; a tab byte also runs through the serial
// remainder unit. A word wrap re-reads the bytes after the break point from
// the text window memory, up to MAX_COLUMNS + 1 bytes. An item's results
// leave through a one-deep staging register and the output register: a row
// moves out when the item's next row is found, and the last row moves out
// once the item is finished and the output register can take it.
// If the receiver stalls, processing waits once both result registers are
// full; nothing is dropped. Reset returns all layout state and registers to
// their defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
module text_row_breaker_with_word_wrap_unit #(
  parameter int MAX_COLUMNS  = trb_pkg::MaxColumns,
  parameter int OFFSET_WIDTH = trb_pkg::OffsetWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] row_start_o,
  output logic [15:0] row_width_o,
  output logic [1:0]  row_end_kind_o,
  output logic        last_of_run_o
);

  trb_pkg::dp_cmd_t    dp_cmd;
  trb_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  trb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  trb_dp #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .text_byte_i    (text_byte_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .row_start_o    (row_start_o),
    .row_width_o    (row_width_o),
    .row_end_kind_o (row_end_kind_o),
    .last_of_run_o  (last_of_run_o),
    .cmd_in_i       (dp_cmd),
    .status_o       (dp_status)
  );

endmodule

[rtl/core/trb_mod.sv]
// ----------------------------------------------------------------------------
// trb_mod
// Bit-serial restoring remainder unit: column modulo tab width, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module trb_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        busy_o,
  output logic [6:0]  rem_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] num_q, num_d;
  logic [6:0]  den_q, den_d;
  logic [6:0]  rem_q, rem_d;
  logic [7:0]  trial;

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    trial = {rem_q, num_q[15]};
    if (start_i) begin
      cnt_d = 5'd16;
      num_d = dividend_i;
      den_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 5'd1;
      num_d = {num_q[14:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 7'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      num_q <= '0;
      den_q <= 7'd1;
      rem_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      num_q <= num_d;
      den_q <= den_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule

[rtl/core/trb_ctrl.sv]
// ----------------------------------------------------------------------------
// trb_ctrl
// Sequencer for the row breaker: accepts an item, walks the byte queue and
// orders emissions and the final flush.
// ----------------------------------------------------------------------------
module trb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trb_pkg::dp_status_t status_i,
  output trb_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_END_CR  = 9'b000000010,
    S_END_FIN = 9'b000000100,
    S_CR_CHK  = 9'b000001000,
    S_RD      = 9'b000010000,
    S_CH      = 9'b000100000,
    S_MOD     = 9'b001000000,
    S_EV      = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = trb_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = trb_pkg::OP_LATCH;
          state_d  = status_i.in_cmd ? S_END_CR : S_CR_CHK;
        end
      end
      S_END_CR: begin
        if (!status_i.crp) begin
          state_d = S_END_FIN;
        end else if (status_i.emit_ok) begin
          cmd_o.op = trb_pkg::OP_END_CR;
          state_d  = S_END_FIN;
        end
      end
      S_END_FIN: begin
        if (status_i.emit_ok) begin
          cmd_o.op = trb_pkg::OP_END_FINAL;
          state_d  = S_DONE;
        end
      end
      S_CR_CHK: begin
        if (!status_i.crp) begin
          cmd_o.op = trb_pkg::OP_ENQ;
          state_d  = S_RD;
        end else if (status_i.emit_ok) begin
          if (status_i.byte_is_lf) begin
            cmd_o.op = trb_pkg::OP_CR_LF;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = trb_pkg::OP_CR_ROW;
          end
        end
      end
      S_RD: begin
        state_d = status_i.q_empty ? S_DONE : S_CH;
      end
      S_CH: begin
        if (status_i.ch_is_tab) begin
          cmd_o.op = trb_pkg::OP_MOD_START;
          state_d  = S_MOD;
        end else begin
          state_d = S_EV;
        end
      end
      S_MOD: begin
        if (!status_i.mod_busy) begin
          state_d = S_EV;
        end
      end
      S_EV: begin
        if (!status_i.ev_emits || status_i.emit_ok) begin
          cmd_o.op = trb_pkg::OP_EVAL;
          state_d  = S_RD;
        end
      end
      S_DONE: begin
        if (!status_i.staged_v) begin
          state_d = S_IDLE;
        end else if (status_i.can_push) begin
          cmd_o.op = trb_pkg::OP_FLUSH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/trb_dp.sv]
// ----------------------------------------------------------------------------
// trb_dp
// Row breaker datapath: configuration, layout state, text window memory,
// tab remainder unit, staged result and output register.
// ----------------------------------------------------------------------------
module trb_dp #(
  parameter int MAX_COLUMNS  = trb_pkg::MaxColumns,
  parameter int OFFSET_WIDTH = trb_pkg::OffsetWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                cmd_i,
  input  logic [7:0]          text_byte_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [23:0]         row_start_o,
  output logic [15:0]         row_width_o,
  output logic [1:0]          row_end_kind_o,
  output logic                last_of_run_o,
  input  trb_pkg::dp_cmd_t    cmd_in_i,
  output trb_pkg::dp_status_t status_o
);

  localparam int AW = $clog2(MAX_COLUMNS + 1);
  localparam int Depth = 1 << AW;
  localparam int PW = $clog2(MAX_COLUMNS + 1);
  localparam int OW = OFFSET_WIDTH;

  logic [6:0]  tab_q;
  logic [7:0]  wrap_q, minw_q;

  logic [7:0]  byte_q, byte_d;
  logic [15:0] column_q, column_d;
  logic [OW-1:0] bo_q, bo_d, rs_q, rs_d, bpo_q, bpo_d, qoff_q, qoff_d;
  logic [15:0] bpc_q, bpc_d;
  logic        hbp_q, hbp_d, crp_q, crp_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [1:0]  nres_q, nres_d;

  logic [7:0]  mem_q [Depth];
  logic [7:0]  rd_q;

  logic          st_v_q, st_v_d;
  logic [OW-1:0] st_start_q, st_start_d;
  logic [15:0]   st_width_q, st_width_d;
  logic [1:0]    st_kind_q, st_kind_d;
  logic          out_v_q, out_v_d;
  logic [23:0]   out_start_q, out_start_d;
  logic [15:0]   out_width_q, out_width_d;
  logic [1:0]    out_kind_q, out_kind_d;
  logic          out_last_q, out_last_d;

  logic [6:0]  tw, rem;
  logic        mod_busy;
  logic [16:0] plus1, tab_sum;
  logic [15:0] nc, ncp1, bpc1, prev1;
  logic        wrap_hit, ev_emits, can_push, emit_ok;
  logic        emit_en;
  logic [OW-1:0] e_start;
  logic [15:0] e_width;
  logic [1:0]  e_kind;
  trb_pkg::dp_op_e op;

  assign op = cmd_in_i.op;
  assign tw = (tab_q == '0) ? 7'd1 : tab_q;

  trb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op == trb_pkg::OP_MOD_START),
    .dividend_i (column_q),
    .divisor_i  (tw),
    .busy_o     (mod_busy),
    .rem_o      (rem)
  );

  // Column arithmetic for the byte at the head of the queue.
  assign plus1   = {1'b0, column_q} + 17'd1;
  assign tab_sum = {1'b0, column_q} + 17'(tw) - 17'(rem);
  assign nc      = trb_pkg::sat_col((rd_q == trb_pkg::ChTab) ? tab_sum : plus1);
  assign ncp1    = trb_pkg::sat_col({1'b0, nc} + 17'd1);
  assign bpc1    = trb_pkg::sat_col({1'b0, bpc_q} + 17'd1);
  assign prev1   = trb_pkg::sat_col(plus1);

  assign wrap_hit = (wrap_q != '0) && (nc >= {8'd0, wrap_q})
                    && (nres_q != 2'(trb_pkg::MaxResults));
  assign ev_emits = (rd_q == trb_pkg::ChLf) || ((rd_q != trb_pkg::ChCr) && wrap_hit);
  assign can_push = !out_v_q || out_ready_i;
  assign emit_ok  = !st_v_q || can_push;

  always_comb begin
    status_o.in_cmd     = cmd_i;
    status_o.crp        = crp_q;
    status_o.byte_is_lf = (byte_q == trb_pkg::ChLf);
    status_o.q_empty    = (qoff_q == bo_q);
    status_o.ch_is_tab  = (rd_q == trb_pkg::ChTab);
    status_o.mod_busy   = mod_busy;
    status_o.ev_emits   = ev_emits;
    status_o.emit_ok    = emit_ok;
    status_o.staged_v   = st_v_q;
    status_o.can_push   = can_push;
  end

  always_comb begin
    byte_d   = byte_q;
    column_d = column_q;
    bo_d     = bo_q;
    rs_d     = rs_q;
    bpc_d    = bpc_q;
    bpo_d    = bpo_q;
    hbp_d    = hbp_q;
    crp_d    = crp_q;
    pend_d   = pend_q;
    qoff_d   = qoff_q;
    nres_d   = nres_q;
    emit_en  = 1'b0;
    e_start  = rs_q;
    e_width  = column_q;
    e_kind   = trb_pkg::KindLineBreak;
    case (op)
      trb_pkg::OP_LATCH: begin
        byte_d = text_byte_i;
        nres_d = '0;
      end
      trb_pkg::OP_CR_LF: begin
        crp_d    = 1'b0;
        emit_en  = 1'b1;
        e_width  = prev1;
        bo_d     = bo_q + OW'(1);
        column_d = '0;
        hbp_d    = 1'b0;
        pend_d   = '0;
        rs_d     = bo_q + OW'(1);
      end
      trb_pkg::OP_CR_ROW, trb_pkg::OP_END_CR: begin
        crp_d    = 1'b0;
        emit_en  = 1'b1;
        column_d = '0;
        hbp_d    = 1'b0;
        pend_d   = '0;
        rs_d     = bo_q;
      end
      trb_pkg::OP_ENQ: begin
        qoff_d = bo_q;
        bo_d   = bo_q + OW'(1);
      end
      trb_pkg::OP_END_FINAL: begin
        emit_en  = 1'b1;
        e_width  = prev1;
        e_kind   = trb_pkg::KindEndOfText;
        column_d = '0;
        bo_d     = '0;
        rs_d     = '0;
        bpc_d    = '0;
        bpo_d    = '0;
        hbp_d    = 1'b0;
        crp_d    = 1'b0;
        pend_d   = '0;
      end
      trb_pkg::OP_EVAL: begin
        if (rd_q == trb_pkg::ChCr) begin
          column_d = nc;
          crp_d    = 1'b1;
          qoff_d   = qoff_q + OW'(1);
        end else if (rd_q == trb_pkg::ChLf) begin
          // Once an item has its full set of rows, further rows are dropped.
          emit_en  = (nres_q != 2'(trb_pkg::MaxResults));
          e_width  = nc;
          column_d = '0;
          hbp_d    = 1'b0;
          pend_d   = '0;
          rs_d     = qoff_q + OW'(1);
          qoff_d   = qoff_q + OW'(1);
        end else if (wrap_hit) begin
          emit_en  = 1'b1;
          e_kind   = trb_pkg::KindWordWrap;
          column_d = '0;
          hbp_d    = 1'b0;
          pend_d   = '0;
          if (hbp_q) begin
            // The bytes after the break point are laid out again.
            e_width = bpc1;
            qoff_d  = bpo_q;
            rs_d    = bpo_q;
          end else if (qoff_q == rs_q) begin
            // A lone crossing byte stays in its row.
            e_width = ncp1;
            rs_d    = qoff_q + OW'(1);
            qoff_d  = qoff_q + OW'(1);
          end else begin
            e_width = prev1;
            rs_d    = qoff_q;
          end
        end else begin
          column_d = nc;
          if (wrap_q == '0) begin
            hbp_d  = 1'b0;
            pend_d = '0;
          end else if ((nc >= {8'd0, minw_q})
                       && ((rd_q == trb_pkg::ChSpace) || (rd_q == trb_pkg::ChTab))) begin
            hbp_d  = 1'b1;
            bpc_d  = nc;
            bpo_d  = qoff_q + OW'(1);
            pend_d = '0;
          end else if (hbp_q) begin
            if (pend_q < PW'(MAX_COLUMNS)) begin
              pend_d = pend_q + PW'(1);
            end else begin
              hbp_d  = 1'b0;
              pend_d = '0;
            end
          end
          qoff_d = qoff_q + OW'(1);
        end
      end
      default: begin
      end
    endcase
    if (emit_en) begin
      nres_d = nres_q + 2'd1;
    end
  end

  // Results are staged one deep so the last one of an item can be flagged.
  always_comb begin
    st_v_d      = st_v_q;
    st_start_d  = st_start_q;
    st_width_d  = st_width_q;
    st_kind_d   = st_kind_q;
    out_v_d     = out_v_q;
    out_start_d = out_start_q;
    out_width_d = out_width_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (emit_en) begin
      if (st_v_q) begin
        out_v_d     = 1'b1;
        out_start_d = 24'(st_start_q);
        out_width_d = st_width_q;
        out_kind_d  = st_kind_q;
        out_last_d  = 1'b0;
      end
      st_v_d     = 1'b1;
      st_start_d = e_start;
      st_width_d = e_width;
      st_kind_d  = e_kind;
    end else if (op == trb_pkg::OP_FLUSH) begin
      out_v_d     = 1'b1;
      out_start_d = 24'(st_start_q);
      out_width_d = st_width_q;
      out_kind_d  = st_kind_q;
      out_last_d  = 1'b1;
      st_v_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((op == trb_pkg::OP_LATCH) && !cmd_i) begin
      mem_q[bo_q[AW-1:0]] <= text_byte_i;
    end
    rd_q <= mem_q[qoff_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    st_start_q  <= st_start_d;
    st_width_q  <= st_width_d;
    st_kind_q   <= st_kind_d;
    out_start_q <= out_start_d;
    out_width_q <= out_width_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q    <= 7'd8;
      wrap_q   <= '0;
      minw_q   <= '0;
      column_q <= '0;
      bo_q     <= '0;
      rs_q     <= '0;
      bpc_q    <= '0;
      bpo_q    <= '0;
      hbp_q    <= 1'b0;
      crp_q    <= 1'b0;
      pend_q   <= '0;
      qoff_q   <= '0;
      nres_q   <= '0;
      st_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          trb_pkg::CfgTabWidth:      tab_q  <= cfg_data_i[6:0];
          trb_pkg::CfgWrapColumn:    wrap_q <= cfg_data_i;
          trb_pkg::CfgMinWrapColumn: minw_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      column_q <= column_d;
      bo_q     <= bo_d;
      rs_q     <= rs_d;
      bpc_q    <= bpc_d;
      bpo_q    <= bpo_d;
      hbp_q    <= hbp_d;
      crp_q    <= crp_d;
      pend_q   <= pend_d;
      qoff_q   <= qoff_d;
      nres_q   <= nres_d;
      st_v_q   <= st_v_d;
      out_v_q  <= out_v_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign row_start_o    = out_start_q;
  assign row_width_o    = out_width_q;
  assign row_end_kind_o = out_kind_q;
  assign last_of_run_o  = out_last_q;

endmodule

[bench/tb_text_row_breaker_with_word_wrap_unit.sv]
// ----------------------------------------------------------------------------
// tb_text_row_breaker_with_word_wrap_unit
// Self-checking bench for the text row breaker. A behavioral row predictor
// tracks every accepted item and queues the rows it should produce. Directed
// tests cover line ends, wrap rules and register extremes. Random phases then
// vary the registers and the idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_row_breaker_with_word_wrap_unit;

  localparam int SettleCycles = 1200;
  localparam int CycleLimit   = 1000000;

  typedef struct packed {
    logic [23:0] start;
    logic [15:0] width;
    logic [1:0]  kind;
    logic        last;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = trb_pkg::CfgTabWidth;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [7:0]  text_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [23:0] row_start_o;
  logic [15:0] row_width_o;
  logic [1:0]  row_end_kind_o;
  logic        last_of_run_o;

  text_row_breaker_with_word_wrap_unit u_top (.*);

  // Predictor state and register copies.
  logic [6:0]  reg_tab_width;
  logic [7:0]  reg_wrap_col;
  logic [7:0]  reg_min_wrap_col;
  logic [15:0] lay_col;
  logic [23:0] lay_offset;
  logic [23:0] lay_row_start;
  logic [15:0] brk_col;
  logic [23:0] brk_offset;
  logic        brk_valid;
  logic        cr_pending;
  logic [7:0]  held_bytes [trb_pkg::MaxColumns];
  int          held_count;

  row_t expected_rows[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   error_count = 0;
  int   items_sent = 0;
  int   rows_checked = 0;
  int   cycle_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Row checker.
  always @(posedge clk_i) begin
    row_t got;
    row_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{row_start_o, row_width_o, row_end_kind_o, last_of_run_o};
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row start=%0d width=%0d kind=%0d last=%0b", $time,
                 got.start, got.width, got.kind, got.last);
        error_count++;
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (got.start !== want.start)
          $display("%0t: row_start expected %0d actual %0d", $time, want.start, got.start);
        if (got.width !== want.width)
          $display("%0t: row_width expected %0d actual %0d", $time, want.width, got.width);
        if (got.kind !== want.kind)
          $display("%0t: row_end_kind expected %0d actual %0d", $time, want.kind, got.kind);
        if (got.last !== want.last)
          $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, got.last);
        if (got !== want) error_count++;
      end
    end
  end

  function automatic logic [15:0] clamp_col(input int v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] next_col(input logic [15:0] c, input logic [7:0] ch);
    int tw;
    if (ch == trb_pkg::ChTab) begin
      tw = (reg_tab_width == 0) ? 1 : int'(reg_tab_width);
      return clamp_col(int'(c) + tw - int'(c) % tw);
    end
    return clamp_col(int'(c) + 1);
  endfunction

  function automatic void open_row(input logic [23:0] start);
    lay_col = '0;
    brk_valid = 1'b0;
    held_count = 0;
    lay_row_start = start;
  endfunction

  function automatic void clear_layout();
    lay_col = '0;
    lay_offset = '0;
    lay_row_start = '0;
    brk_col = '0;
    brk_offset = '0;
    brk_valid = 1'b0;
    cr_pending = 1'b0;
    held_count = 0;
  endfunction

  function automatic void add_row(ref row_t rows[$], input logic [23:0] start,
                                  input logic [15:0] width, input logic [1:0] kind);
    if (rows.size() < trb_pkg::MaxResults) rows.push_back('{start, width, kind, 1'b0});
  endfunction

  // Lays out one accepted item and queues the rows it finishes.
  function automatic void predict_rows(input logic is_eot, input logic [7:0] b);
    row_t        rows[$];
    logic [7:0]  q[$];
    logic [7:0]  nq[$];
    int          qi;
    logic [23:0] qoff;
    logic [23:0] st;
    logic [15:0] prev;
    logic [15:0] nc;
    logic        done;
    done = 1'b0;
    if (is_eot) begin
      if (cr_pending) begin
        add_row(rows, lay_row_start, lay_col, trb_pkg::KindLineBreak);
        open_row(lay_offset);
      end
      add_row(rows, lay_row_start, clamp_col(int'(lay_col) + 1), trb_pkg::KindEndOfText);
      clear_layout();
      done = 1'b1;
    end else if (cr_pending) begin
      cr_pending = 1'b0;
      if (b == trb_pkg::ChLf) begin
        // The LF of a CR LF pair closes the row the CR left open.
        lay_col = clamp_col(int'(lay_col) + 1);
        add_row(rows, lay_row_start, lay_col, trb_pkg::KindLineBreak);
        lay_offset = lay_offset + 24'd1;
        open_row(lay_offset);
        done = 1'b1;
      end else begin
        add_row(rows, lay_row_start, lay_col, trb_pkg::KindLineBreak);
        open_row(lay_offset);
      end
    end
    if (!done) begin
      q.push_back(b);
      qi = 0;
      qoff = lay_offset;
      lay_offset = lay_offset + 24'd1;
      while (qi < q.size()) begin
        prev = lay_col;
        nc = next_col(prev, q[qi]);
        if (q[qi] == trb_pkg::ChCr) begin
          lay_col = nc;
          cr_pending = 1'b1;
          qi++;
          qoff++;
        end else if (q[qi] == trb_pkg::ChLf) begin
          lay_col = nc;
          add_row(rows, lay_row_start, lay_col, trb_pkg::KindLineBreak);
          open_row(qoff + 24'd1);
          qi++;
          qoff++;
        end else if (reg_wrap_col != 0 && nc >= reg_wrap_col
                     && rows.size() < trb_pkg::MaxResults) begin
          if (brk_valid && held_count + (q.size() - qi) <= trb_pkg::MaxColumns + 1) begin
            // Bytes after the break point are laid out again on the new row.
            st = brk_offset;
            add_row(rows, lay_row_start, clamp_col(int'(brk_col) + 1),
                    trb_pkg::KindWordWrap);
            nq.delete();
            for (int i = 0; i < held_count; i++) nq.push_back(held_bytes[i]);
            for (int i = qi; i < q.size(); i++) nq.push_back(q[i]);
            q = nq;
            qi = 0;
            qoff = st;
            open_row(st);
          end else if (qoff == lay_row_start) begin
            add_row(rows, lay_row_start, clamp_col(int'(nc) + 1), trb_pkg::KindWordWrap);
            open_row(qoff + 24'd1);
            qi++;
            qoff++;
          end else begin
            add_row(rows, lay_row_start, clamp_col(int'(prev) + 1), trb_pkg::KindWordWrap);
            open_row(qoff);
          end
        end else begin
          lay_col = nc;
          if (reg_wrap_col == 0) begin
            brk_valid = 1'b0;
            held_count = 0;
          end else if (nc >= reg_min_wrap_col
                       && (q[qi] == trb_pkg::ChSpace || q[qi] == trb_pkg::ChTab)) begin
            brk_valid = 1'b1;
            brk_col = nc;
            brk_offset = qoff + 24'd1;
            held_count = 0;
          end else if (brk_valid) begin
            if (held_count < trb_pkg::MaxColumns) begin
              held_bytes[held_count] = q[qi];
              held_count++;
            end else begin
              brk_valid = 1'b0;
              held_count = 0;
            end
          end
          qi++;
          qoff++;
        end
      end
    end
    if (rows.size() > 0) rows[rows.size() - 1].last = 1'b1;
    foreach (rows[i]) expected_rows.push_back(rows[i]);
  endfunction

  task automatic send_item(input logic is_eot, input logic [7:0] b);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    cmd_i <= is_eot;
    text_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_rows(is_eot, b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // Waits until the block is idle, then writes one register.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      trb_pkg::CfgTabWidth:      reg_tab_width = val[6:0];
      trb_pkg::CfgWrapColumn:    reg_wrap_col = val;
      trb_pkg::CfgMinWrapColumn: reg_min_wrap_col = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_line_ends();
    send_text("ab\tc\n");
    send_text("x\r\ny\rz");
    send_item(1'b0, trb_pkg::ChCr);
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_wrap_rules();
    write_reg(trb_pkg::CfgTabWidth, 8'd4);
    write_reg(trb_pkg::CfgWrapColumn, 8'd8);
    write_reg(trb_pkg::CfgMinWrapColumn, 8'd2);
    send_text("a bb\tcc dddddddddd e");
    send_item(1'b1, 8'h00);
    // With a wrap column of one, every byte crosses on its own row.
    write_reg(trb_pkg::CfgWrapColumn, 8'd1);
    send_text("xy\t");
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_register_extremes();
    write_reg(trb_pkg::CfgTabWidth, 8'd0);
    write_reg(trb_pkg::CfgWrapColumn, 8'd255);
    write_reg(trb_pkg::CfgMinWrapColumn, 8'd255);
    send_item(1'b0, 8'h00);
    send_item(1'b0, trb_pkg::ChTab);
    send_item(1'b0, 8'hFF);
    write_reg(trb_pkg::CfgTabWidth, 8'd127);
    send_text("\t\t ");
    send_item(1'b1, 8'h00);
    write_reg(trb_pkg::CfgTabWidth, 8'd64);
    write_reg(trb_pkg::CfgMinWrapColumn, 8'd0);
    send_text("\tq\t\t\t\tw");
    send_item(1'b1, 8'h00);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'(8'h61 + $urandom_range(25));
    if (r < 75) return trb_pkg::ChSpace;
    if (r < 80) return trb_pkg::ChTab;
    if (r < 86) return trb_pkg::ChLf;
    if (r < 91) return trb_pkg::ChCr;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    int wrap;
    send_idle_pct = 0;
    write_reg(trb_pkg::CfgTabWidth, 8'($urandom_range(1, 8)));
    wrap = ($urandom_range(4) == 0) ? 0 : int'($urandom_range(3, 30));
    write_reg(trb_pkg::CfgWrapColumn, 8'(wrap));
    write_reg(trb_pkg::CfgMinWrapColumn, 8'($urandom_range(0, wrap)));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) send_item(1'b1, 8'($urandom_range(255)));
      else send_item(1'b0, pick_byte());
    end
  endtask

  initial begin
    reg_tab_width = 7'd8;
    reg_wrap_col = '0;
    reg_min_wrap_col = '0;
    clear_layout();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_line_ends();
    test_wrap_rules();
    test_register_extremes();
    test_random_phase(0, 0, 35);
    test_random_phase(59, 0, 35);
    test_random_phase(0, 59, 35);
    test_random_phase(32, 32, 35);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d items and %0d rows over line ends, wraps and register extremes,",
             items_sent, rows_checked);
    $display("with idling and stalls on both channels.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/trb_pkg.sv
rtl/core/trb_mod.sv
rtl/core/trb_ctrl.sv
rtl/core/trb_dp.sv
rtl/core/text_row_breaker_with_word_wrap_unit.sv
bench/tb_text_row_breaker_with_word_wrap_unit.sv
